// ===== sv/midpoint_line_rasterizer_unit_macros.svh =====
// Assertion macros for the midpoint line rasterizer checker.
// Every macro expects signals named clk and arst_n in the scope where it is used.
`ifndef MIDPOINT_LINE_RASTERIZER_UNIT_MACROS_SVH
`define MIDPOINT_LINE_RASTERIZER_UNIT_MACROS_SVH

// same-cycle implication
`define MLR_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("midpoint line rasterizer: assertion failed");

// next-cycle implication
`define MLR_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("midpoint line rasterizer: assertion failed");

// delayed implication
`define MLR_ASSERT_DLY2(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##2 (cons)) \
		else $error("midpoint line rasterizer: assertion failed");

`endif

// ===== sv/mlr_pkg.sv =====
// Shared widths, microcode types and the microprogram ROM for the line rasterizer.
// No dependencies; used by the datapath, the top level and the checker.
package mlr_pkg;

	localparam int CoordBits = 6;
	localparam int InDataW   = ((4 * CoordBits + 7) / 8) * 8;
	localparam int OutDataW  = ((2 * CoordBits + 7) / 8) * 8;
	localparam int DecW      = CoordBits + 3;
	localparam int CntW      = CoordBits + 1;
	localparam int IncW      = CoordBits + 2;

	typedef logic [CoordBits-1:0] coord_t;

	// microcode address space
	typedef logic [1:0] uaddr_t;
	localparam uaddr_t UA_WAIT  = 2'd0;
	localparam uaddr_t UA_SETUP = 2'd1;
	localparam uaddr_t UA_WALK  = 2'd2;

	typedef enum logic [1:0] {
		COND_ALWAYS,
		COND_IN_FIRE,
		COND_WALK_DONE
	} ucond_t;

	typedef struct packed {
		logic   in_ready;
		logic   load;
		logic   setup;
		logic   out_valid;
		ucond_t cond;
		uaddr_t tgt_true;
		uaddr_t tgt_false;
	} uword_t;

	// datapath controls and status between sequencer and datapath
	typedef struct packed {
		logic load;
		logic setup;
		logic step;
	} dp_ctrl_t;

	typedef struct packed {
		logic last;
	} dp_stat_t;

	// microprogram: wait for a segment, set up the walk, emit one pixel per beat
	function automatic uword_t urom(input uaddr_t addr);
		uword_t w;
		w = '{in_ready: 1'b0, load: 1'b0, setup: 1'b0, out_valid: 1'b0,
			cond: COND_ALWAYS, tgt_true: UA_WAIT, tgt_false: UA_WAIT};
		unique case (addr)
			UA_WAIT: begin
				w.in_ready  = 1'b1;
				w.load      = 1'b1;
				w.cond      = COND_IN_FIRE;
				w.tgt_true  = UA_SETUP;
				w.tgt_false = UA_WAIT;
			end
			UA_SETUP: begin
				w.setup     = 1'b1;
				w.cond      = COND_ALWAYS;
				w.tgt_true  = UA_WALK;
				w.tgt_false = UA_WALK;
			end
			UA_WALK: begin
				w.out_valid = 1'b1;
				w.cond      = COND_WALK_DONE;
				w.tgt_true  = UA_WAIT;
				w.tgt_false = UA_WALK;
			end
			default: begin
				w.cond      = COND_ALWAYS;
				w.tgt_true  = UA_WAIT;
				w.tgt_false = UA_WAIT;
			end
		endcase
		return w;
	endfunction

endpackage

// ===== sv/mlr_datapath.sv =====
// Datapath of the line rasterizer: endpoint ordering, slope setup and the midpoint walk.
// Depends on mlr_pkg; driven by the microcode sequencer in the top level.
module mlr_datapath import mlr_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  dp_ctrl_t ctrl,
	input  coord_t   start_x,
	input  coord_t   start_y,
	input  coord_t   end_x,
	input  coord_t   end_y,
	output dp_stat_t stat,
	output coord_t   pixel_x,
	output coord_t   pixel_y
);

	coord_t                 ax_q, ay_q, bx_q, by_q;
	coord_t                 walk_x_q, walk_y_q;
	logic signed [DecW-1:0] decision_q;
	logic [CntW-1:0]        steps_left_q;
	logic [IncW-1:0]        inc_minor_q;
	logic signed [DecW-1:0] inc_diag_q;
	logic                   is_steep_q, y_down_q;

	logic                   swap;
	logic [CoordBits:0]     dx;
	logic signed [CoordBits:0] dy;
	coord_t                 ady, major, minor;
	logic                   steep;
	logic                   diag, step_x, step_y;
	logic signed [DecW-1:0] dec_add;

	// order endpoints so x never decreases
	assign swap = start_x > end_x;

	// slope setup from the ordered endpoints
	always_comb begin
		dx    = {1'b0, bx_q} - {1'b0, ax_q};
		dy    = $signed({1'b0, by_q}) - $signed({1'b0, ay_q});
		ady   = dy[CoordBits] ? coord_t'(-dy) : coord_t'(dy);
		steep = ady > dx[CoordBits-1:0];
		major = steep ? ady : dx[CoordBits-1:0];
		minor = steep ? dx[CoordBits-1:0] : ady;
	end

	// midpoint decision for one step
	always_comb begin
		diag    = decision_q > 0;
		step_x  = is_steep_q ? diag : 1'b1;
		step_y  = is_steep_q ? 1'b1 : diag;
		dec_add = diag ? inc_diag_q : $signed({1'b0, inc_minor_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ax_q         <= '0;
			ay_q         <= '0;
			bx_q         <= '0;
			by_q         <= '0;
			walk_x_q     <= '0;
			walk_y_q     <= '0;
			decision_q   <= '0;
			steps_left_q <= '0;
			inc_minor_q  <= '0;
			inc_diag_q   <= '0;
			is_steep_q   <= 1'b0;
			y_down_q     <= 1'b0;
		end else begin
			if (ctrl.load) begin
				ax_q <= swap ? end_x   : start_x;
				ay_q <= swap ? end_y   : start_y;
				bx_q <= swap ? start_x : end_x;
				by_q <= swap ? start_y : end_y;
			end
			if (ctrl.setup) begin
				walk_x_q     <= ax_q;
				walk_y_q     <= ay_q;
				is_steep_q   <= steep;
				y_down_q     <= dy[CoordBits];
				decision_q   <= $signed({2'b00, minor, 1'b0}) - $signed({3'b000, major});
				inc_minor_q  <= {1'b0, minor, 1'b0};
				inc_diag_q   <= $signed({2'b00, minor, 1'b0}) - $signed({2'b00, major, 1'b0});
				steps_left_q <= {1'b0, major};
			end else if (ctrl.step) begin
				decision_q   <= decision_q + dec_add;
				steps_left_q <= steps_left_q - CntW'(1);
				if (step_x)
					walk_x_q <= walk_x_q + coord_t'(1);
				if (step_y)
					walk_y_q <= y_down_q ? walk_y_q - coord_t'(1) : walk_y_q + coord_t'(1);
			end
		end
	end

	assign stat.last = steps_left_q == '0;
	assign pixel_x   = walk_x_q;
	assign pixel_y   = walk_y_q;

endmodule

// ===== sv/midpoint_line_rasterizer_unit.sv =====
// Midpoint line rasterizer: a microcode sequencer drives the walk datapath.
// Depends on mlr_pkg and mlr_datapath.
//
// Use: one beat on the s_axis channel carries a segment as two endpoints.
// The block orders the endpoints left to right and emits every pixel of the
// segment on m_axis, one beat per pixel in walking order, start and end
// included. tlast is high on the final pixel; a single point gives one beat
// with tlast set.
// The first pixel is offered after the segment beat is latched and ordered
// and the slope is then set up. Afterwards one pixel leaves per cycle while
// m_axis_tready is high.
// A new segment is taken only once the last pixel of the previous one has
// left, since the pixel walk loop of the sequencer runs to its end first.
// s_axis_tready is high only while the sequencer waits for a segment.
// A stall on m_axis holds the current pixel and the walk state unchanged.
// Reset clears the microprogram counter to the wait step; the block then takes a
// segment at once.
module midpoint_line_rasterizer_unit import mlr_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	input  logic [InDataW-1:0]  s_axis_tdata,   // start_x, start_y, end_x, end_y
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	output logic [OutDataW-1:0] m_axis_tdata,   // pixel_x, pixel_y, zero pad
	output logic                m_axis_tlast
);

	uaddr_t   upc_q, upc_next;
	uword_t   uw;
	logic     in_fire, out_fire, cond_hit;
	dp_ctrl_t ctrl;
	dp_stat_t stat;
	coord_t   pixel_x, pixel_y;

	assign uw = urom(upc_q);

	assign in_fire  = s_axis_tvalid & uw.in_ready;
	assign out_fire = uw.out_valid & m_axis_tready;

	always_comb begin
		unique case (uw.cond)
			COND_ALWAYS:    cond_hit = 1'b1;
			COND_IN_FIRE:   cond_hit = in_fire;
			COND_WALK_DONE: cond_hit = out_fire & stat.last;
			default:        cond_hit = 1'b1;
		endcase
		upc_next = cond_hit ? uw.tgt_true : uw.tgt_false;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			upc_q <= UA_WAIT;
		else
			upc_q <= upc_next;
	end

	always_comb begin
		ctrl.load  = uw.load & in_fire;
		ctrl.setup = uw.setup;
		ctrl.step  = out_fire;
	end

	mlr_datapath u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (ctrl),
		.start_x (s_axis_tdata[0*CoordBits +: CoordBits]),
		.start_y (s_axis_tdata[1*CoordBits +: CoordBits]),
		.end_x   (s_axis_tdata[2*CoordBits +: CoordBits]),
		.end_y   (s_axis_tdata[3*CoordBits +: CoordBits]),
		.stat    (stat),
		.pixel_x (pixel_x),
		.pixel_y (pixel_y)
	);

	assign s_axis_tready = uw.in_ready;
	assign m_axis_tvalid = uw.out_valid;
	assign m_axis_tdata  = OutDataW'({pixel_y, pixel_x});
	assign m_axis_tlast  = stat.last;

endmodule

// ===== sv/mlr_checker.sv =====
// Port-level checker for the line rasterizer, bound to the top level.
// Depends on mlr_pkg and midpoint_line_rasterizer_unit_macros.svh.
`include "midpoint_line_rasterizer_unit_macros.svh"

module mlr_checker import mlr_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                s_axis_tvalid,
	input logic                s_axis_tready,
	input logic                m_axis_tvalid,
	input logic                m_axis_tready,
	input logic [OutDataW-1:0] m_axis_tdata,
	input logic                m_axis_tlast
);

	logic in_beat, out_beat;

	assign in_beat  = s_axis_tvalid & s_axis_tready;
	assign out_beat = m_axis_tvalid & m_axis_tready;

	// one segment at a time: never taking input while pixels are offered
	`MLR_ASSERT_IMP(a_one_segment, s_axis_tready, !m_axis_tvalid)
	// first pixel offered after the load and setup steps that follow the segment beat
	`MLR_ASSERT_DLY2(a_first_pixel, in_beat, m_axis_tvalid)
	// a run without its last pixel keeps offering pixels
	`MLR_ASSERT_NXT(a_run_continues, out_beat && !m_axis_tlast, m_axis_tvalid)
	// the last pixel returns the block to waiting for a segment
	`MLR_ASSERT_NXT(a_run_ends, out_beat && m_axis_tlast, s_axis_tready)
	// a stalled pixel beat holds its data
	`MLR_ASSERT_NXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))

endmodule

bind midpoint_line_rasterizer_unit mlr_checker u_mlr_checker (.*);
